// ===== hw/rtl/rsls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsls_pkg
// Shared types, register map, constants and color blend helpers for the
// shift light strip renderer.
// ----------------------------------------------------------------------------
package rsls_pkg;

    localparam int RPM_W      = 16;
    localparam int RGB_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int PAIR_W     = 48;
    localparam int ADDR_W     = 6;
    localparam int APB_W      = 64;
    localparam int REG_SEL_LSB = 3;
    localparam int REG_SEL_W  = 3;
    localparam int IDX_OUT_W  = 4;
    localparam int LVL_OUT_W  = 5;

    localparam int DIV_NUM_W  = 32;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_BITS   = 2;
    localparam int DIV_CYC    = DIV_NUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);

    localparam int MS_PER_S   = 1000;
    localparam logic [RPM_W-1:0]  HOLD_BAND = 16'd75;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

    localparam int MODE_EN     = 0;
    localparam int MODE_MIRROR = 1;

    localparam logic [31:0]       RST_START_MID   = 32'h1388_0BB8;
    localparam logic [31:0]       RST_RED_BLINK   = 32'h1D4C_1B58;
    localparam logic [15:0]       RST_BLINK_MS    = 16'd200;
    localparam logic [7:0]        RST_LED_COUNT   = 8'd16;
    localparam logic [1:0]        RST_MODE        = 2'b01;
    localparam logic [PAIR_W-1:0] RST_LOW_MID     = 48'hFFFF_0000_FF00;
    localparam logic [PAIR_W-1:0] RST_HIGH_BLINK  = 48'h0000_FFFF_0000;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_START_MID  = 3'd0,
        REG_RED_BLINK  = 3'd1,
        REG_BLINK_MS   = 3'd2,
        REG_LED_COUNT  = 3'd3,
        REG_MODE       = 3'd4,
        REG_LOW_MID    = 3'd5,
        REG_HIGH_BLINK = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [31:0]       start_mid;
        logic [31:0]       red_blink;
        logic [15:0]       blink_ms;
        logic [7:0]        led_count;
        logic [1:0]        mode;
        logic [PAIR_W-1:0] low_mid;
        logic [PAIR_W-1:0] high_blink;
    } t_cfg;

    typedef enum logic [1:0] {
        DIV_PHASE,
        DIV_LEVEL,
        DIV_MIX
    } t_div_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_PHASE_GO,
        ST_PHASE_WAIT,
        ST_LEVEL_GO,
        ST_LEVEL_WAIT,
        ST_COLOR,
        ST_MIX_GO,
        ST_MIX_WAIT,
        ST_BLEND,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    set_dark;
        logic    clr_blink;
        logic    set_full;
        logic    div_start;
        t_div_op div_op;
        logic    cap_phase;
        logic    cap_level;
        logic    set_low;
        logic    set_t_full;
        logic    cap_t;
        logic    blend;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic dark;
        logic blink_hit;
        logic full;
        logic below_mid;
        logic at_red;
        logic div_done;
        logic emit_last;
    } t_dp_sts;

    // a + (b - a) * t / 255, quotient truncated toward zero
    function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] t);
        logic signed [9:0]  diff;
        logic signed [18:0] prod;
        logic [17:0]        mag;
        logic [17:0]        quo;
        logic [9:0]         sum;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        prod = diff * $signed({1'b0, t});
        mag  = prod[18] ? 18'(-prod) : 18'(prod);
        quo  = (mag + 18'd1 + (mag >> 8)) >> 8;
        sum  = prod[18] ? ({2'b00, a} - 10'(quo)) : ({2'b00, a} + 10'(quo));
        return sum[CHAN_W-1:0];
    endfunction

    function automatic logic [RGB_W-1:0] mix_rgb(input logic [RGB_W-1:0] a,
                                                 input logic [RGB_W-1:0] b,
                                                 input logic [CHAN_W-1:0] t);
        return {mix_chan(a[23:16], b[23:16], t),
                mix_chan(a[15:8],  b[15:8],  t),
                mix_chan(a[7:0],   b[7:0],   t)};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rsls_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsls_regs
// APB register file holding the strip configuration.
// ----------------------------------------------------------------------------
module rsls_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rsls_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rsls_pkg::APB_W-1:0]  pwdata,
    output logic      [rsls_pkg::APB_W-1:0]  prdata,
    output logic                            pready,
    output rsls_pkg::t_cfg                  o_cfg
);
    import rsls_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[REG_SEL_LSB +: REG_SEL_W]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_mid  <= RST_START_MID;
            r_cfg.red_blink  <= RST_RED_BLINK;
            r_cfg.blink_ms   <= RST_BLINK_MS;
            r_cfg.led_count  <= RST_LED_COUNT;
            r_cfg.mode       <= RST_MODE;
            r_cfg.low_mid    <= RST_LOW_MID;
            r_cfg.high_blink <= RST_HIGH_BLINK;
        end else if (wr_en) begin
            case (reg_sel)
                REG_START_MID:  r_cfg.start_mid  <= pwdata[31:0];
                REG_RED_BLINK:  r_cfg.red_blink  <= pwdata[31:0];
                REG_BLINK_MS:   r_cfg.blink_ms   <= pwdata[15:0];
                REG_LED_COUNT:  r_cfg.led_count  <= pwdata[7:0];
                REG_MODE:       r_cfg.mode       <= pwdata[1:0];
                REG_LOW_MID:    r_cfg.low_mid    <= pwdata[PAIR_W-1:0];
                REG_HIGH_BLINK: r_cfg.high_blink <= pwdata[PAIR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_START_MID:  prdata = APB_W'(r_cfg.start_mid);
            REG_RED_BLINK:  prdata = APB_W'(r_cfg.red_blink);
            REG_BLINK_MS:   prdata = APB_W'(r_cfg.blink_ms);
            REG_LED_COUNT:  prdata = APB_W'(r_cfg.led_count);
            REG_MODE:       prdata = APB_W'(r_cfg.mode);
            REG_LOW_MID:    prdata = APB_W'(r_cfg.low_mid);
            REG_HIGH_BLINK: prdata = APB_W'(r_cfg.high_blink);
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rsls_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsls_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rsls_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rsls_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [rsls_pkg::DIV_DEN_W-1:0] i_den,
    output logic      [rsls_pkg::DIV_NUM_W-1:0] o_quo,
    output logic                               o_done
);
    import rsls_pkg::*;

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] n_num;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        logic [DIV_DEN_W:0] trial;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {n_rem, n_num[DIV_NUM_W-1]};
            if (trial >= {1'b0, r_den}) begin
                n_rem = DIV_DEN_W'(trial - {1'b0, r_den});
                n_num = {n_num[DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_DEN_W-1:0];
                n_num = {n_num[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== hw/rtl/rsls_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsls_dp
// Datapath: rpm hold, bar level and color registers, divider operand
// selection, blink counter and the per-LED output register.
// ----------------------------------------------------------------------------
module rsls_dp #(
    parameter int MAX_LEDS       = 16,
    parameter int RENDER_RATE_HZ = 50
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rsls_pkg::t_cfg                i_cfg,
    input  wire rsls_pkg::t_dp_cmd             i_cmd,
    output rsls_pkg::t_dp_sts                  o_sts,
    input  wire logic [rsls_pkg::RPM_W-1:0]     i_engine_rpm,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [rsls_pkg::IDX_OUT_W-1:0]      o_led_index,
    output logic [rsls_pkg::CHAN_W-1:0]         o_red,
    output logic [rsls_pkg::CHAN_W-1:0]         o_green,
    output logic [rsls_pkg::CHAN_W-1:0]         o_blue,
    output logic [rsls_pkg::LVL_OUT_W-1:0]      o_bar_level,
    output logic                               o_last
);
    import rsls_pkg::*;

    localparam int LW      = $clog2(MAX_LEDS);
    localparam int NW      = $clog2(MAX_LEDS + 1);
    localparam int RMS_RAW = MS_PER_S / RENDER_RATE_HZ;
    localparam int RMS     = (RMS_RAW == 0) ? 1 : RMS_RAW;
    // ceil(2^26 / RMS): exact for numerators below 2^16 with RMS up to 1000
    localparam int HALF_SH    = 26;
    localparam int HALF_PW    = DIV_DEN_W + HALF_SH + 1;
    localparam int HALF_RECIP = ((1 << HALF_SH) + RMS - 1) / RMS;

    logic [RPM_W-1:0]     start_rpm, mid_rpm, red_rpm, blink_rpm;
    logic                 enabled, mirrored;
    logic [NW-1:0]        strip_len, slot_cnt;

    logic [RPM_W-1:0]     r_held;
    logic [31:0]          r_blink;
    logic [DIV_DEN_W-1:0] half_num, half_quo, half_cnt;
    logic [HALF_PW-1:0]   half_prod;
    logic [NW-1:0]        r_level;
    logic [RGB_W-1:0]     r_color;
    logic [CHAN_W-1:0]    r_t;

    logic [RPM_W+NW-1:0]  prod_level;
    logic [RPM_W+CHAN_W-1:0] prod_mix;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 div_done;

    logic [LW-1:0]        r_pos;
    logic [NW-1:0]        pos_ext;
    logic                 pos_last, lit, out_free, out_load;
    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [RGB_W-1:0]     r_out_rgb;
    logic [LVL_OUT_W-1:0] r_out_level;
    logic                 r_out_last;

    assign start_rpm = i_cfg.start_mid[15:0];
    assign mid_rpm   = i_cfg.start_mid[31:16];
    assign red_rpm   = i_cfg.red_blink[15:0];
    assign blink_rpm = i_cfg.red_blink[31:16];
    assign enabled   = i_cfg.mode[MODE_EN];
    assign mirrored  = i_cfg.mode[MODE_MIRROR];

    assign strip_len = (i_cfg.led_count > 8'(MAX_LEDS)) ? NW'(MAX_LEDS)
                                                         : NW'(i_cfg.led_count);
    assign slot_cnt  = mirrored ? (strip_len >> 1) : strip_len;

    assign o_sts.dark      = !enabled || (slot_cnt == '0) || (r_held < start_rpm);
    assign o_sts.blink_hit = r_held >= blink_rpm;
    assign o_sts.full      = (r_held >= red_rpm) || (red_rpm <= start_rpm);
    assign o_sts.below_mid = r_held < mid_rpm;
    assign o_sts.at_red    = r_held >= red_rpm;
    assign o_sts.div_done  = div_done;
    assign o_sts.emit_last = out_load && pos_last;

    // rpm hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.load) begin
            if (i_engine_rpm == '0 || i_engine_rpm >= r_held) begin
                r_held <= i_engine_rpm;
            end else if ((r_held - i_engine_rpm) > HOLD_BAND) begin
                r_held <= i_engine_rpm + HOLD_BAND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink <= '0;
        end else if (i_cmd.set_dark || i_cmd.clr_blink) begin
            r_blink <= '0;
        end else if (i_cmd.cap_phase) begin
            r_blink <= r_blink + 32'd1;
        end
    end

    // renders per half blink period, rounded, at least one
    assign half_num  = (i_cfg.blink_ms >> 1) + DIV_DEN_W'(RMS / 2);
    assign half_prod = HALF_PW'(half_num) * HALF_PW'(HALF_RECIP);
    assign half_quo  = half_prod[HALF_SH +: DIV_DEN_W];
    assign half_cnt  = (half_quo == '0) ? DIV_DEN_W'(1) : half_quo;

    assign prod_level = (RPM_W+NW)'(r_held - start_rpm) * (RPM_W+NW)'(slot_cnt - NW'(1));
    assign prod_mix   = (RPM_W+CHAN_W)'(r_held - mid_rpm) * (RPM_W+CHAN_W)'(CHAN_MAX);

    always_comb begin
        case (i_cmd.div_op)
            DIV_PHASE: begin
                div_num = r_blink;
                div_den = half_cnt;
            end
            DIV_LEVEL: begin
                div_num = DIV_NUM_W'(prod_level);
                div_den = red_rpm - start_rpm;
            end
            DIV_MIX: begin
                div_num = DIV_NUM_W'(prod_mix);
                div_den = red_rpm - mid_rpm;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    rsls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_t) begin
            r_t <= div_quo[CHAN_W-1:0];
        end else if (i_cmd.set_t_full) begin
            r_t <= CHAN_MAX;
        end
        if (i_cmd.set_dark) begin
            r_level <= '0;
            r_color <= '0;
        end else if (i_cmd.cap_phase) begin
            r_level <= slot_cnt;
            r_color <= div_quo[0] ? RGB_W'(0) : i_cfg.high_blink[PAIR_W-1:RGB_W];
        end else begin
            if (i_cmd.set_full) begin
                r_level <= slot_cnt;
            end else if (i_cmd.cap_level) begin
                r_level <= NW'(div_quo) + NW'(1);
            end
            if (i_cmd.set_low) begin
                r_color <= i_cfg.low_mid[RGB_W-1:0];
            end else if (i_cmd.blend) begin
                r_color <= mix_rgb(i_cfg.low_mid[PAIR_W-1:RGB_W],
                                   i_cfg.high_blink[RGB_W-1:0], r_t);
            end
        end
    end

    // per-LED output register
    assign pos_ext  = NW'(r_pos);
    assign pos_last = r_pos == LW'(MAX_LEDS - 1);
    assign lit      = (pos_ext < r_level) ||
                      (mirrored && (pos_ext < strip_len) && (pos_ext >= strip_len - r_level));
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = i_cmd.emit && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
            r_pos       <= pos_last ? '0 : r_pos + 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx   <= IDX_OUT_W'(r_pos);
            r_out_rgb   <= lit ? r_color : RGB_W'(0);
            r_out_level <= LVL_OUT_W'(r_level);
            r_out_last  <= pos_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_index = r_out_idx;
    assign o_red       = r_out_rgb[23:16];
    assign o_green     = r_out_rgb[15:8];
    assign o_blue      = r_out_rgb[7:0];
    assign o_bar_level = r_out_level;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

// ===== hw/rtl/rsls_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsls_ctrl
// Render sequencer: classifies the held rpm, runs the divisions in order
// and steps the LED emission.
// ----------------------------------------------------------------------------
module rsls_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rsls_pkg::t_dp_sts i_sts,
    output rsls_pkg::t_dp_cmd      o_cmd
);
    import rsls_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = r_state != ST_IDLE;
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_CLASS;
            end
            ST_CLASS: begin
                if (i_sts.dark)           n_state = ST_EMIT;
                else if (i_sts.blink_hit) n_state = ST_PHASE_GO;
                else if (i_sts.full)      n_state = ST_COLOR;
                else                      n_state = ST_LEVEL_GO;
            end
            ST_PHASE_GO:   n_state = ST_PHASE_WAIT;
            ST_PHASE_WAIT: begin
                if (i_sts.div_done) n_state = ST_EMIT;
            end
            ST_LEVEL_GO:   n_state = ST_LEVEL_WAIT;
            ST_LEVEL_WAIT: begin
                if (i_sts.div_done) n_state = ST_COLOR;
            end
            ST_COLOR: begin
                if (i_sts.below_mid)   n_state = ST_EMIT;
                else if (i_sts.at_red) n_state = ST_BLEND;
                else                   n_state = ST_MIX_GO;
            end
            ST_MIX_GO:     n_state = ST_MIX_WAIT;
            ST_MIX_WAIT: begin
                if (i_sts.div_done) n_state = ST_BLEND;
            end
            ST_BLEND:      n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.emit_last) n_state = ST_IDLE;
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.div_op = DIV_PHASE;
        o_cmd.load   = accept;
        case (r_state)
            ST_CLASS: begin
                o_cmd.set_dark  = i_sts.dark;
                o_cmd.clr_blink = !i_sts.dark && !i_sts.blink_hit;
                o_cmd.set_full  = !i_sts.dark && !i_sts.blink_hit && i_sts.full;
            end
            ST_PHASE_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_PHASE;
            end
            ST_PHASE_WAIT: begin
                o_cmd.cap_phase = i_sts.div_done;
            end
            ST_LEVEL_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_LEVEL;
            end
            ST_LEVEL_WAIT: begin
                o_cmd.cap_level = i_sts.div_done;
            end
            ST_COLOR: begin
                o_cmd.set_low    = i_sts.below_mid;
                o_cmd.set_t_full = !i_sts.below_mid && i_sts.at_red;
            end
            ST_MIX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_MIX;
            end
            ST_MIX_WAIT: begin
                o_cmd.cap_t = i_sts.div_done;
            end
            ST_BLEND: begin
                o_cmd.blend = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rpm_shift_light_strip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_shift_light_strip
// Shift light renderer: one rpm reading in, MAX_LEDS colored LED items out.
// Dark renders start emitting with no divide, blink renders after one and bar
//   renders after up to two radix-4 divides (level, then color mix).
// A new rpm reading is accepted only once the last LED item of the current
//   render is loaded into the output register; output stalls delay that.
// Reset (synchronous, active low) clears held rpm, blink count, sequencer
//   and output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module rpm_shift_light_strip #(
    parameter int MAX_LEDS       = 16,
    parameter int RENDER_RATE_HZ = 50
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rsls_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rsls_pkg::APB_W-1:0]     pwdata,
    output logic      [rsls_pkg::APB_W-1:0]     prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [rsls_pkg::RPM_W-1:0]     i_engine_rpm,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [rsls_pkg::IDX_OUT_W-1:0]      o_led_index,
    output logic [rsls_pkg::CHAN_W-1:0]         o_red,
    output logic [rsls_pkg::CHAN_W-1:0]         o_green,
    output logic [rsls_pkg::CHAN_W-1:0]         o_blue,
    output logic [rsls_pkg::LVL_OUT_W-1:0]      o_bar_level,
    output logic                               o_last
);
    import rsls_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    rsls_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rsls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rsls_dp #(
        .MAX_LEDS       (MAX_LEDS),
        .RENDER_RATE_HZ (RENDER_RATE_HZ)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_engine_rpm (i_engine_rpm),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_led_index  (o_led_index),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_bar_level  (o_bar_level),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
